// File: sv/spc_pkg.sv
// Shared types and constants for the stepper position controller.
// Holds the command codes, register indexes and channel payload structs.
// No dependencies.
package spc_pkg;

  // Command codes carried by each input transaction
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_MOVE_REL = 3'd1,
    CMD_MOVE_ABS = 3'd2,
    CMD_RUN      = 3'd3,
    CMD_STOP     = 3'd4,
    CMD_ZERO     = 3'd5
  } cmd_t;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic REG_INVERT_DIRECTION = 1'b0;
  localparam logic REG_STEP_MODE        = 1'b1;

  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] step_value;
    logic [31:0]        period_ticks;
    logic               run_reverse;
  } in_item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               motor_backward;
    logic [1:0]         drive_type;
    logic signed [31:0] position;
    logic signed [31:0] target;
    logic               busy_res;
  } out_item_t;

endpackage

// File: sv/stepper_position_controller.sv
// Stepper position controller top level: command input, step result output, APB registers.
// Depends on spc_pkg for command codes, register indexes and payload structs.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------
//   input    | in_valid / in_ready   | in_data   (in_item_t)
//   result   | out_valid / out_ready | out_data  (out_item_t)
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// Each transaction is captured in the input register, then the state update and
// the result are computed in one pass and written to the result register, from which
// the result is presented; one transaction per cycle is taken unless the result stalls.
// rst_n is synchronous, active low, and clears motion state, valid flags and config registers.
// A stalled result register holds the input register; input stalls only when both are full.
module stepper_position_controller
  import spc_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned PERIOD_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam int unsigned POS_EXT = (POSITION_BITS > 32) ? POSITION_BITS : 32;
  localparam int unsigned PER_EXT = (PERIOD_BITS > 32) ? PERIOD_BITS : 32;
  localparam logic [PERIOD_BITS-1:0] PER_MAX = {PERIOD_BITS{1'b1}};

  // Configuration registers
  logic       invert_direction_r;
  logic [1:0] step_mode_r;

  // Motion state
  logic [POSITION_BITS-1:0] step_position_r, step_position_nxt;
  logic [POSITION_BITS-1:0] target_position_r, target_position_nxt;
  logic                     moving_reverse_r, moving_reverse_nxt;
  logic                     continuous_run_r, continuous_run_nxt;
  logic [PERIOD_BITS-1:0]   step_period_r, step_period_nxt;
  logic [PERIOD_BITS-1:0]   elapsed_ticks_r, elapsed_ticks_nxt;

  // Pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  logic advance;
  logic cfg_write;

  // Advance when the input register holds a transaction and the result slot frees up
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // APB register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_INVERT_DIRECTION: prdata = DATA_BITS'(invert_direction_r);
      REG_STEP_MODE:        prdata = DATA_BITS'(step_mode_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_direction_r <= 1'b0;
      step_mode_r        <= 2'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_INVERT_DIRECTION: invert_direction_r <= pwdata[0];
        REG_STEP_MODE:        step_mode_r        <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Execute one command against the motion state
  always_comb begin
    logic [POSITION_BITS-1:0] val;
    logic [PER_EXT-1:0]       per_ext;
    logic [PERIOD_BITS-1:0]   per_sat;
    logic                     per_zero;
    logic                     busy_now;
    logic                     pulse;
    logic [POSITION_BITS-1:0] tgt;
    logic [POS_EXT-1:0]       pos_ext;
    logic [POS_EXT-1:0]       tgt_ext;

    step_position_nxt   = step_position_r;
    target_position_nxt = target_position_r;
    moving_reverse_nxt  = moving_reverse_r;
    continuous_run_nxt  = continuous_run_r;
    step_period_nxt     = step_period_r;
    elapsed_ticks_nxt   = elapsed_ticks_r;
    pulse               = 1'b0;

    val      = POSITION_BITS'(in_item_r.step_value);
    per_ext  = PER_EXT'(in_item_r.period_ticks);
    per_sat  = (per_ext > PER_EXT'(PER_MAX)) ? PER_MAX : per_ext[PERIOD_BITS-1:0];
    per_zero = (in_item_r.period_ticks == 32'd0);
    busy_now = continuous_run_r || (step_position_r != target_position_r);

    unique case (in_item_r.command)
      CMD_TICK: begin
        if (elapsed_ticks_r != PER_MAX) begin
          elapsed_ticks_nxt = elapsed_ticks_r + PERIOD_BITS'(1);
        end
        if (busy_now && (elapsed_ticks_nxt >= step_period_r)) begin
          pulse = 1'b1;
          if (moving_reverse_r) begin
            step_position_nxt = step_position_r - POSITION_BITS'(1);
          end else begin
            step_position_nxt = step_position_r + POSITION_BITS'(1);
          end
          elapsed_ticks_nxt = elapsed_ticks_nxt - step_period_r;
        end
      end
      CMD_MOVE_REL: begin
        target_position_nxt = step_position_r;
        continuous_run_nxt  = 1'b0;
        if (!per_zero) begin
          target_position_nxt = step_position_r + val;
          step_period_nxt     = per_sat;
          elapsed_ticks_nxt   = '0;
          moving_reverse_nxt  = val[POSITION_BITS-1];
        end
      end
      CMD_MOVE_ABS: begin
        target_position_nxt = step_position_r;
        continuous_run_nxt  = 1'b0;
        if (!per_zero) begin
          target_position_nxt = val;
          step_period_nxt     = per_sat;
          elapsed_ticks_nxt   = '0;
          moving_reverse_nxt  = !($signed(step_position_r) < $signed(val));
        end
      end
      CMD_RUN: begin
        target_position_nxt = step_position_r;
        continuous_run_nxt  = 1'b0;
        if (!per_zero) begin
          moving_reverse_nxt = in_item_r.run_reverse;
          step_period_nxt    = per_sat;
          elapsed_ticks_nxt  = '0;
          continuous_run_nxt = 1'b1;
        end
      end
      CMD_STOP: begin
        target_position_nxt = step_position_r;
        continuous_run_nxt  = 1'b0;
      end
      CMD_ZERO: begin
        continuous_run_nxt  = 1'b0;
        step_position_nxt   = '0;
        target_position_nxt = '0;
      end
      default: ;
    endcase

    // Build the result from the updated state
    tgt     = continuous_run_nxt ? step_position_nxt : target_position_nxt;
    pos_ext = POS_EXT'(step_position_nxt);
    tgt_ext = POS_EXT'(tgt);

    out_item_nxt.step_pulse     = pulse;
    out_item_nxt.motor_backward = moving_reverse_nxt ^ invert_direction_r;
    out_item_nxt.drive_type     = step_mode_r;
    out_item_nxt.position       = pos_ext[31:0];
    out_item_nxt.target         = tgt_ext[31:0];
    out_item_nxt.busy_res       = continuous_run_nxt ||
                                  (step_position_nxt != target_position_nxt);
  end

  // Hold state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      step_position_r   <= '0;
      target_position_r <= '0;
      moving_reverse_r  <= 1'b0;
      continuous_run_r  <= 1'b0;
      step_period_r     <= '0;
      elapsed_ticks_r   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r       <= 1'b1;
        step_position_r   <= step_position_nxt;
        target_position_r <= target_position_nxt;
        moving_reverse_r  <= moving_reverse_nxt;
        continuous_run_r  <= continuous_run_nxt;
        step_period_r     <= step_period_nxt;
        elapsed_ticks_r   <= elapsed_ticks_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
